FILE: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while rst is high
`define LOS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also holds during reset
`define LOS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lsg_pkg.sv
// ----------------------------------------------------------------------------
// lsg_pkg
// shared types and constants of the tile grid line of sight block
// ----------------------------------------------------------------------------
package lsg_pkg;

   localparam int PIX_W  = 16;   // pixel coordinates, signed
   localparam int FRAC_W = 16;   // fraction bits of the walk accumulator
   localparam int ACC_W  = PIX_W + FRAC_W;
   localparam int DEN_W  = 15;   // magnitude of a line delta
   localparam int NUM_W  = DEN_W + FRAC_W;
   localparam int CNT_W  = 5;

   localparam logic [1:0] CSR_MAX_DIST = 2'd0;
   localparam logic [1:0] CSR_COLS     = 2'd1;
   localparam logic [1:0] CSR_ROWS     = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQUARE,
      ST_COMPARE,
      ST_TILE,
      ST_ADDR,
      ST_CHECK,
      ST_LINE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_STEP
   } state_type;

endpackage

FILE: src/lsg_div.sv
// ----------------------------------------------------------------------------
// lsg_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lsg_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lsg_pkg::NUM_W-1:0]  dividend,
   input  logic [lsg_pkg::DEN_W-1:0]  divisor,
   output logic                       done,
   output logic [lsg_pkg::NUM_W-1:0]  quotient
);
   import lsg_pkg::*;

   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] dvd_ff, dvd_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic             fits;

   assign shifted = {rem_ff[DEN_W-1:0], dvd_ff[NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         dvd_in = dividend;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? shifted - {1'b0, den_ff} : shifted;
         dvd_in = {dvd_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

FILE: src/tile_grid_line_of_sight.sv
// ----------------------------------------------------------------------------
// tile_grid_line_of_sight
// occupancy tile map with pixel-walk line of sight queries
// ----------------------------------------------------------------------------
// After reset the block sweeps the tile map to empty, one tile per cycle
// (MAP_ROWS*MAP_COLS tiles, 4096 at the defaults), with busy high. A beat is
// taken when start is high and busy is low. A tile write beat finishes in its
// accept cycle, busy stays low and no result follows. A query beat yields one
// result on rsp_* for exactly one cycle, marked by rsp_strobe, which the
// receiver must take as it comes; the strobe shows in the first cycle with
// busy low again. A query runs the range check (square, compare) and the
// eye tile probe (tile index, address, check), then per sight line a setup
// in which the slope comes from a one-bit-per-cycle divider, and then a walk
// in which each pixel goes through the step, tile index, address with the
// map read and the check, with one closing step. Two lines that each run the
// full length along their major axis make the longest query.
// Configuration writes are taken at any edge with csr_we high and belong
// between queries.
// ----------------------------------------------------------------------------
module tile_grid_line_of_sight #(
   parameter int MAP_COLS  = 64,
   parameter int MAP_ROWS  = 64,
   parameter int TILE_SIZE = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic         req_op,
   input  logic [5:0]   req_tile_row,
   input  logic [5:0]   req_tile_col,
   input  logic         req_tile_solid,
   input  logic [12:0]  req_viewer_x,
   input  logic [12:0]  req_viewer_y,
   input  logic [7:0]   req_viewer_w,
   input  logic [7:0]   req_viewer_h,
   input  logic [12:0]  req_target_x,
   input  logic [12:0]  req_target_y,
   input  logic [7:0]   req_target_w,
   input  logic [7:0]   req_target_h,
   output logic         rsp_strobe,
   output logic         rsp_visible,
   output logic         rsp_beyond_range,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_wdata
);
   import lsg_pkg::*;

   localparam int DEPTH   = MAP_ROWS * MAP_COLS;
   localparam int ADDR_W  = $clog2(DEPTH);
   // exact reciprocal for pixel to tile on nonnegative 15-bit pixels
   localparam int IDX_W   = PIX_W - 1;
   localparam int K_SH    = IDX_W + $clog2(TILE_SIZE);
   localparam int RECIP   = ((2 ** K_SH) + TILE_SIZE - 1) / TILE_SIZE;
   localparam int PROD_W  = IDX_W + K_SH + 1;
   localparam logic [8:0] COLS_C = 9'(MAP_COLS);
   localparam logic [8:0] ROWS_C = 9'(MAP_ROWS);

   // tile map, one bit per tile
   logic              tile_mem [0:DEPTH-1];
   logic              rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic              mem_wdata;

   state_type state_ff, state_in;

   // configuration
   logic [12:0] max_dist_ff;
   logic [6:0]  cols_used_ff;
   logic [6:0]  rows_used_ff;

   // query operands
   logic signed [13:0]      dx_ff, dy_ff;
   logic [27:0]             dxsq_ff, dysq_ff, limsq_ff;
   logic signed [PIX_W-1:0] ex_ff, ey_ff, tx_ff, ty_ff;
   logic [7:0]              tw_ff, th_ff;
   logic                    k_ff;     // which target edge is walked
   logic                    eye_ff;   // current probe is the eye tile

   // walk state
   logic                    xmaj_ff;
   logic signed [PIX_W-1:0] p_ff, pend_ff;
   logic                    step_neg_ff, minor_neg_ff;
   logic signed [ACC_W-1:0] acc_ff, inc_ff;
   logic [DEN_W-1:0]        num_ff, den_ff;

   // tile probe pipeline
   logic signed [PIX_W-1:0] px_ff, py_ff;
   logic                    negx_ff, negy_ff;
   logic [IDX_W-1:0]        tc_ff, tr_ff;
   logic                    on_ff;

   // result register
   logic rsp_strobe_ff, rsp_visible_ff, rsp_beyond_ff;

   logic [ADDR_W-1:0] clr_ff;

   // divider
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_q;

   lsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({num_ff, {FRAC_W{1'b0}}}),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // ---------------- combinational terms ----------------
   logic                    accept;
   logic [28:0]             d2;
   logic                    beyond;
   logic                    blocked;
   logic                    line_done;
   logic signed [PIX_W-1:0] ex_new, ey_new;
   logic signed [PIX_W-1:0] tpx, tpy, ldx, ldy;
   logic [PIX_W-1:0]        adx_f, ady_f;
   logic [DEN_W-1:0]        adx, ady;
   logic                    xmaj;
   logic signed [ACC_W-1:0] acc_next;
   logic [PROD_W-1:0]       prod_x, prod_y;
   logic [8:0]              cols_eff, rows_eff;
   logic                    on_map;
   logic [23:0]             probe_addr_w, wr_addr_w;
   logic                    wr_ok;

   assign accept    = start && !busy;
   assign d2        = {1'b0, dxsq_ff} + {1'b0, dysq_ff};
   assign beyond    = d2 >= {1'b0, limsq_ff};
   assign blocked   = on_ff && rdata_ff;
   assign line_done = p_ff == pend_ff;

   // eye point: center x, quarter height
   assign ex_new = {{3{req_viewer_x[12]}}, req_viewer_x} + PIX_W'(req_viewer_w[7:1]);
   assign ey_new = {{3{req_viewer_y[12]}}, req_viewer_y} + PIX_W'(req_viewer_h[7:2]);

   // target point of the current line: left or right mid-edge
   assign tpx   = tx_ff + (k_ff ? PIX_W'(tw_ff) : '0);
   assign tpy   = ty_ff + PIX_W'(th_ff[7:1]);
   assign ldx   = tpx - ex_ff;
   assign ldy   = tpy - ey_ff;
   assign adx_f = ldx[PIX_W-1] ? PIX_W'(-ldx) : PIX_W'(ldx);
   assign ady_f = ldy[PIX_W-1] ? PIX_W'(-ldy) : PIX_W'(ldy);
   assign adx   = adx_f[DEN_W-1:0];
   assign ady   = ady_f[DEN_W-1:0];
   // x-major when |slope| < 1.5
   assign xmaj  = {1'b0, ady, 1'b0} < ({2'b0, adx} + {1'b0, adx, 1'b0});

   assign acc_next = acc_ff + inc_ff;

   assign prod_x = PROD_W'(px_ff[IDX_W-1:0]) * PROD_W'(RECIP);
   assign prod_y = PROD_W'(py_ff[IDX_W-1:0]) * PROD_W'(RECIP);

   // used counts above the map size act as the map size
   assign cols_eff = ({2'b0, cols_used_ff} > COLS_C) ? COLS_C : {2'b0, cols_used_ff};
   assign rows_eff = ({2'b0, rows_used_ff} > ROWS_C) ? ROWS_C : {2'b0, rows_used_ff};
   assign on_map   = !negx_ff && !negy_ff
                     && (tc_ff < IDX_W'(cols_eff)) && (tr_ff < IDX_W'(rows_eff));
   assign probe_addr_w = 24'(tr_ff) * 24'(MAP_COLS) + 24'(tc_ff);

   assign wr_ok     = ({3'b0, req_tile_row} < ROWS_C) && ({3'b0, req_tile_col} < COLS_C);
   assign wr_addr_w = 24'(req_tile_row) * 24'(MAP_COLS) + 24'(req_tile_col);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && req_op == OP_QUERY) state_in = ST_SQUARE;
         end
         ST_SQUARE:  state_in = ST_COMPARE;
         ST_COMPARE: state_in = beyond ? ST_IDLE : ST_TILE;
         ST_TILE:    state_in = ST_ADDR;
         ST_ADDR:    state_in = ST_CHECK;
         ST_CHECK: begin
            if (eye_ff) begin
               state_in = blocked ? ST_IDLE : ST_LINE;
            end else if (blocked) begin
               state_in = k_ff ? ST_IDLE : ST_LINE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_LINE:      state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) state_in = ST_STEP;
         end
         ST_STEP: state_in = line_done ? ST_IDLE : ST_TILE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      busy      = 1'b1;
      div_start = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = wr_addr_w[ADDR_W-1:0];
      mem_wdata = req_tile_solid;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 1'b0;
         end
         ST_IDLE: begin
            // busy is low here, so start alone takes the beat
            busy   = 1'b0;
            mem_we = start && req_op == OP_WRITE && wr_ok;
         end
         ST_DIV_START: div_start = 1'b1;
         default:      busy = 1'b1;
      endcase
   end

   // ---------------- memory ----------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tile_mem[mem_waddr] <= mem_wdata;
      end
   end

   // the read is issued in the address cycle and lands in the check cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_ADDR) begin
         rdata_ff <= tile_mem[probe_addr_w[ADDR_W-1:0]];
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         max_dist_ff   <= 13'd1024;
         cols_used_ff  <= 7'd64;
         rows_used_ff  <= 7'd64;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_DIST: max_dist_ff  <= csr_wdata;
               CSR_COLS:     cols_used_ff <= csr_wdata[6:0];
               CSR_ROWS:     rows_used_ff <= csr_wdata[6:0];
               default:      max_dist_ff  <= max_dist_ff;
            endcase
         end
         rsp_strobe_ff <= (state_ff != ST_IDLE) && (state_ff != ST_CLEAR)
                          && (state_in == ST_IDLE);
      end
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dx_ff <= $signed({req_target_x[12], req_target_x})
                        - $signed({req_viewer_x[12], req_viewer_x});
               dy_ff <= $signed({req_target_y[12], req_target_y})
                        - $signed({req_viewer_y[12], req_viewer_y});
               ex_ff <= ex_new;
               ey_ff <= ey_new;
               tx_ff <= {{3{req_target_x[12]}}, req_target_x};
               ty_ff <= {{3{req_target_y[12]}}, req_target_y};
               tw_ff <= req_target_w;
               th_ff <= req_target_h;
               k_ff  <= 1'b0;
            end
         end
         ST_SQUARE: begin
            dxsq_ff  <= 28'(dx_ff) * 28'(dx_ff);
            dysq_ff  <= 28'(dy_ff) * 28'(dy_ff);
            limsq_ff <= 28'({1'b0, max_dist_ff} + 14'd1) * 28'({1'b0, max_dist_ff} + 14'd1);
         end
         ST_COMPARE: begin
            rsp_visible_ff <= 1'b0;
            rsp_beyond_ff  <= beyond;
            px_ff          <= ex_ff;
            py_ff          <= ey_ff;
            eye_ff         <= 1'b1;
         end
         ST_TILE: begin
            negx_ff <= px_ff[PIX_W-1];
            negy_ff <= py_ff[PIX_W-1];
            tc_ff   <= prod_x[K_SH +: IDX_W];
            tr_ff   <= prod_y[K_SH +: IDX_W];
         end
         ST_ADDR: begin
            on_ff <= on_map;
         end
         ST_CHECK: begin
            // second line follows a blocked first line
            if (!eye_ff && blocked) k_ff <= 1'b1;
            eye_ff <= 1'b0;
         end
         ST_LINE: begin
            xmaj_ff      <= xmaj;
            p_ff         <= xmaj ? ex_ff : ey_ff;
            pend_ff      <= xmaj ? tpx : tpy;
            step_neg_ff  <= xmaj ? ldx[PIX_W-1] : ldy[PIX_W-1];
            minor_neg_ff <= xmaj ? ldy[PIX_W-1] : ldx[PIX_W-1];
            acc_ff       <= xmaj ? {ey_ff, {FRAC_W{1'b0}}} : {ex_ff, {FRAC_W{1'b0}}};
            num_ff       <= xmaj ? ady : adx;
            den_ff       <= xmaj ? adx : ady;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (den_ff == '0) begin
                  inc_ff <= '0;
               end else if (minor_neg_ff) begin
                  inc_ff <= -$signed(ACC_W'(div_q));
               end else begin
                  inc_ff <= $signed(ACC_W'(div_q));
               end
            end
         end
         ST_STEP: begin
            if (line_done) begin
               rsp_visible_ff <= 1'b1;
            end else begin
               acc_ff <= acc_next;
               px_ff  <= xmaj_ff ? p_ff : acc_next[ACC_W-1:FRAC_W];
               py_ff  <= xmaj_ff ? acc_next[ACC_W-1:FRAC_W] : p_ff;
               p_ff   <= p_ff + (step_neg_ff ? {PIX_W{1'b1}} : PIX_W'(1));
            end
         end
         default: eye_ff <= eye_ff;
      endcase
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_visible      = rsp_visible_ff;
   assign rsp_beyond_range = rsp_beyond_ff;

endmodule

FILE: src/lsg_checker.sv
// ----------------------------------------------------------------------------
// lsg_checker
// port-level checks of the tile grid line of sight block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsg_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_op,
   input logic rsp_strobe,
   input logic rsp_visible,
   input logic rsp_beyond_range
);
   logic both_flags;
   logic query_beat;

   assign both_flags = rsp_visible && rsp_beyond_range;
   assign query_beat = start && !busy && req_op;

   `LOS_ASSERT_ALWAYS(a_no_rsp_in_reset, clock, reset |=> !rsp_strobe, "result beat in reset")
   `LOS_ASSERT(a_flags_exclusive, clock, reset, rsp_strobe |-> !both_flags, "both flags set")
   `LOS_ASSERT(a_query_busy, clock, reset, query_beat |=> busy, "query beat left busy low")
   `LOS_ASSERT(a_rsp_after_work, clock, reset, rsp_strobe |-> $past(busy), "result without work")

endmodule

bind tile_grid_line_of_sight lsg_checker u_lsg_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_op           (req_op),
   .rsp_strobe       (rsp_strobe),
   .rsp_visible      (rsp_visible),
   .rsp_beyond_range (rsp_beyond_range)
);

FILE: dv/tile_grid_line_of_sight_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_grid_line_of_sight_test
// self-checking bench for the tile grid line of sight block
// ----------------------------------------------------------------------------
// Drives tile writes and sight queries through the start/busy port, keeps its
// own copy of the tile map and registers, predicts the visible and
// beyond_range bits of every query, and compares each strobed result with the
// oldest prediction. Several register settings are run, extremes included.
// ----------------------------------------------------------------------------
module tile_grid_line_of_sight_test;
   import lsg_pkg::*;

   localparam int STALL_LIMIT = 300000;   // worst query plus the clearing sweep, with margin

   typedef struct {
      bit        op;
      bit [5:0]  row;
      bit [5:0]  col;
      bit        solid;
      bit [12:0] vx;
      bit [12:0] vy;
      bit [7:0]  vw;
      bit [7:0]  vh;
      bit [12:0] tx;
      bit [12:0] ty;
      bit [7:0]  tw;
      bit [7:0]  th;
   } beat_type;

   // sight predictor with its own map and registers, plus the pending results
   class scoreboard_type;
      bit          tiles[4096];
      int unsigned max_dist = 1024;
      int unsigned cols_used = 64;
      int unsigned rows_used = 64;
      bit          pend_visible[$];
      bit          pend_beyond[$];
      int          mismatches;
      int          n_writes, n_queries, n_visible, n_beyond;

      function void set_reg(logic [1:0] idx, bit [12:0] v);
         case (idx)
            CSR_MAX_DIST: max_dist = 32'(v);
            CSR_COLS:     cols_used = 32'(v[6:0]);
            CSR_ROWS:     rows_used = 32'(v[6:0]);
            default: ;
         endcase
      endfunction

      function bit tile_at(longint px, longint py);
         longint c, r;
         c = (cols_used > 64) ? 64 : cols_used;
         r = (rows_used > 64) ? 64 : rows_used;
         if (px < 0 || py < 0) return 0;
         if (px / 32 >= c || py / 32 >= r) return 0;
         return tiles[(py / 32) * 64 + px / 32];
      endfunction

      function longint floor16(longint a);
         longint q;
         q = a / 65536;
         if (a % 65536 != 0 && a < 0) q -= 1;
         return q;
      endfunction

      // signed q.16 per-step increment, truncated toward zero
      function longint slope_step(longint dmin, longint dmaj);
         longint amin, amaj, q;
         amin = dmin < 0 ? -dmin : dmin;
         amaj = dmaj < 0 ? -dmaj : dmaj;
         if (amaj == 0) return 0;
         q = (amin * 65536) / amaj;
         return dmin < 0 ? -q : q;
      endfunction

      function bit sight_clear(longint x1, longint y1, longint x2, longint y2);
         longint dx, dy, adx, ady, inc, stp, p, acc;
         dx = x2 - x1;
         dy = y2 - y1;
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         if (2 * ady < 3 * adx) begin
            // x-major walk
            inc = slope_step(dy, dx);
            stp = dx > 0 ? 1 : -1;
            p = x1;
            acc = y1 * 65536;
            while (p != x2) begin
               acc += inc;
               if (tile_at(p, floor16(acc))) return 0;
               p += stp;
            end
         end else begin
            inc = slope_step(dx, dy);
            stp = dy > 0 ? 1 : -1;
            p = y1;
            acc = x1 * 65536;
            while (p != y2) begin
               acc += inc;
               if (tile_at(floor16(acc), p)) return 0;
               p += stp;
            end
         end
         return 1;
      endfunction

      function void note_beat(beat_type b);
         longint vx, vy, tx, ty, dx, dy, lim, ex, ey;
         bit vis, far;
         if (b.op == OP_WRITE) begin
            tiles[b.row * 64 + b.col] = b.solid;
            n_writes++;
            return;
         end
         vx = $signed(b.vx);
         vy = $signed(b.vy);
         tx = $signed(b.tx);
         ty = $signed(b.ty);
         dx = tx - vx;
         dy = ty - vy;
         lim = longint'(max_dist) + 1;
         vis = 0;
         far = (dx * dx + dy * dy >= lim * lim);
         ex = vx + b.vw / 2;
         ey = vy + b.vh / 4;
         if (!far && !tile_at(ex, ey)) begin
            for (int k = 0; k < 2 && !vis; k++)
               vis = sight_clear(ex, ey, tx + k * longint'(b.tw), ty + b.th / 2);
         end
         pend_visible = {pend_visible, vis};
         pend_beyond = {pend_beyond, far};
         n_queries++;
         n_visible += vis;
         n_beyond += far;
      endfunction

      function void check_result(logic vis, logic far);
         bit ev, ef;
         if (pend_visible.size() == 0) begin
            $error("result with no query pending: visible %0b beyond_range %0b", vis, far);
            mismatches++;
            return;
         end
         ev = pend_visible.pop_front();
         ef = pend_beyond.pop_front();
         if (vis !== ev) begin
            $error("visible expected %0b actual %0b", ev, vis);
            mismatches++;
         end
         if (far !== ef) begin
            $error("beyond_range expected %0b actual %0b", ef, far);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        rsp_strobe, rsp_visible, rsp_beyond_range;
   logic        csr_we = 0;
   logic [1:0]  csr_index = CSR_MAX_DIST;
   logic [12:0] csr_wdata = '0;
   beat_type    cur = '{default: 0};

   scoreboard_type sb = new();
   int          stall_cycles = 0;
   bit          idle_on = 1;

   always #10 clock = ~clock;

   tile_grid_line_of_sight i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (cur.op),
      .req_tile_row     (cur.row),
      .req_tile_col     (cur.col),
      .req_tile_solid   (cur.solid),
      .req_viewer_x     (cur.vx),
      .req_viewer_y     (cur.vy),
      .req_viewer_w     (cur.vw),
      .req_viewer_h     (cur.vh),
      .req_target_x     (cur.tx),
      .req_target_y     (cur.ty),
      .req_target_w     (cur.tw),
      .req_target_h     (cur.th),
      .rsp_strobe       (rsp_strobe),
      .rsp_visible      (rsp_visible),
      .rsp_beyond_range (rsp_beyond_range),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // accepted beats feed the predictor, strobed results are checked,
   // and a watchdog counts cycles where nothing moves
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_beat(cur);
         if (rsp_strobe) sb.check_result(rsp_visible, rsp_beyond_range);
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // one beat: optional idle burst, then hold start until busy is low at an edge
   task automatic send_beat(beat_type b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      cur <= b;
      start <= 1;
      do @(posedge clock); while (busy);
   endtask

   // drain all pending results, let the block settle, then write all registers
   task automatic set_config(int unsigned view_range, int unsigned cols, int unsigned rows);
      start <= 0;
      while (sb.pend_visible.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
      csr_we <= 1;
      csr_index <= CSR_MAX_DIST;
      csr_wdata <= 13'(view_range);
      @(posedge clock);
      sb.set_reg(CSR_MAX_DIST, 13'(view_range));
      csr_index <= CSR_COLS;
      csr_wdata <= 13'(cols);
      @(posedge clock);
      sb.set_reg(CSR_COLS, 13'(cols));
      csr_index <= CSR_ROWS;
      csr_wdata <= 13'(rows);
      @(posedge clock);
      sb.set_reg(CSR_ROWS, 13'(rows));
      csr_we <= 0;
   endtask

   function automatic beat_type tile_beat(int r, int c, bit s);
      beat_type b = '{default: 0};
      b.op = OP_WRITE;
      b.row = 6'(r);
      b.col = 6'(c);
      b.solid = s;
      return b;
   endfunction

   function automatic beat_type sight_beat(int vx, int vy, int vw, int vh,
                                           int tx, int ty, int tw, int th);
      beat_type b = '{default: 0};
      b.op = OP_QUERY;
      b.vx = 13'(vx);  b.vy = 13'(vy);  b.vw = 8'(vw);  b.vh = 8'(vh);
      b.tx = 13'(tx);  b.ty = 13'(ty);  b.tw = 8'(tw);  b.th = 8'(th);
      // tile fields carry junk on queries, they must be ignored
      b.row = 6'($urandom);
      b.col = 6'($urandom);
      b.solid = 1'($urandom);
      return b;
   endfunction

   // random beat: map writes, nearby queries over the map, and raw noise
   function automatic beat_type random_beat();
      beat_type b;
      int unsigned pick, reach;
      int vx, vy;
      pick = $urandom_range(0, 99);
      reach = (sb.max_dist + 40 > 500) ? 500 : sb.max_dist + 40;
      if (pick < 30) begin
         // keep the map about a quarter solid
         b = tile_beat($urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 3) == 0);
         b.vx = 13'($urandom);  b.vy = 13'($urandom);
         b.tx = 13'($urandom);  b.ty = 13'($urandom);
      end else if (pick < 85) begin
         vx = $urandom_range(0, 2200) - 100;
         vy = $urandom_range(0, 2200) - 100;
         b = sight_beat(vx, vy, $urandom_range(0, 255), $urandom_range(0, 255),
                        vx + $urandom_range(0, 2 * reach) - int'(reach),
                        vy + $urandom_range(0, 2 * reach) - int'(reach),
                        $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
         b = sight_beat($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
         b.op = 1'($urandom);
      end
      return b;
   endfunction

   initial begin
      int unsigned view_range, cols, rows, n;
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed: default registers, corner tiles, boundary and corner cases
      set_config(1024, 64, 64);
      send_beat(tile_beat(0, 0, 1));
      send_beat(tile_beat(63, 63, 1));
      send_beat(tile_beat(2, 3, 1));
      send_beat(tile_beat(63, 0, 0));
      // eye on a solid tile
      send_beat(sight_beat(0, 0, 8, 8, 100, 0, 4, 4));
      // eye sits on the target point
      send_beat(sight_beat(500, 500, 0, 0, 500, 500, 0, 0));
      // just inside and just outside the range
      send_beat(sight_beat(200, 200, 0, 0, 1224, 200, 0, 0));
      send_beat(sight_beat(200, 200, 0, 0, 1225, 200, 0, 0));
      // horizontal lines through the solid tile at row 2, col 3
      send_beat(sight_beat(40, 80, 0, 0, 200, 70, 0, 20));
      send_beat(sight_beat(40, 80, 0, 0, 200, 70, 60, 20));
      // field extremes
      send_beat(sight_beat(-4096, -4096, 255, 255, 4095, 4095, 255, 255));
      send_beat(sight_beat(-4096, -4096, 0, 0, -3996, -4096, 255, 0));
      send_beat(sight_beat(4095, 4095, 255, 255, 4000, 4000, 255, 255));
      // steep, y-major line
      send_beat(sight_beat(300, 300, 0, 0, 310, 600, 4, 0));
      send_beat(sight_beat(2020, 2020, 0, 0, 1990, 1990, 255, 255));

      // random phases over several register settings, extremes included
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin view_range = 0;    cols = 1;   rows = 1;   n = 60;  end
            1: begin view_range = 8191; cols = 64;  rows = 64;  n = 12;  end
            2: begin view_range = 300;  cols = 127; rows = 0;   n = 60;  end
            3: begin view_range = 300;  cols = 0;   rows = 127; n = 60;  end
            default: begin
               view_range = $urandom_range(30, 450);
               cols = $urandom_range(1, 64);
               rows = $urandom_range(1, 64);
               n = 130;
            end
         endcase
         // no idling in the last stretch
         idle_on = (ph != 9);
         set_config(view_range, cols, rows);
         repeat (n) send_beat(random_beat());
      end

      start <= 0;
      while (sb.pend_visible.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d tile writes and %0d queries (%0d visible, %0d out of range)",
               sb.n_writes, sb.n_queries, sb.n_visible, sb.n_beyond);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/lsg_pkg.sv
src/lsg_div.sv
src/tile_grid_line_of_sight.sv
src/lsg_checker.sv
dv/tile_grid_line_of_sight_test.sv
